@@ src/b2y_pkg.sv @@
// ----------------------------------------------------------------------------
// b2y_pkg
// Types and constants shared by the BGR to YUV 4:2:0 converter modules: the
// pixel and result words, the scan position passed down the pipeline, the
// register indexes and the register reset values.
// ----------------------------------------------------------------------------
package b2y_pkg;

	// Width of the row and column counters and of the frame size registers.
	localparam int CNT_W         = 13;
	localparam int LUMA_ADDR_W   = 24;
	localparam int CHROMA_ADDR_W = 22;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [CNT_W-1:0] RST_FRAME_WIDTH  = 13'd320;
	localparam logic [CNT_W-1:0] RST_FRAME_HEIGHT = 13'd240;

	// One input word: a BGR pixel.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// One output word: luma sample, optional chroma sample and frame marker.
	typedef struct packed {
		logic [7:0]               luma_value;
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic                     chroma_write;
		logic                     chroma_plane;
		logic [7:0]               chroma_value;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic                     frame_last;
	} result_t;

	// Position of the pixel in the frame, as produced by the scan counters.
	typedef struct packed {
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic                     chroma_write;
		logic                     chroma_plane;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic                     frame_last;
	} scan_pos_t;

endpackage

@@ src/bgr_to_yuv420_converter_unit.sv @@
// ----------------------------------------------------------------------------
// bgr_to_yuv420_converter_unit
// BGR to YUV 4:2:0 planar converter, one pixel word in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
// Pixel words arrive on the pixel channel in bitmap order, bottom row first,
// columns left to right. Each accepted pixel gives exactly one result word:
// the luma sample with its plane offset, on even columns one chroma sample
// (U on even rows, V on odd rows, plane flag set for V) and a flag on the
// last pixel of the frame.
// Frame width and height are written on the cfg channel, which is always
// ready; any write to a known register restarts the frame at the bottom row.
// A pixel taken at one edge goes into the input register, then through the
// conversion logic into the result register once that register can move.
// Throughput is one pixel per cycle while the receiver does not stall, set by
// the input register, the conversion logic and the result register in a row.
// When the receiver stalls the result register holds its word, the input
// register fills behind it, and pixel_ready then drops until it moves.
// After reset the frame is 320 by 240 and the scan starts at the bottom row;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module bgr_to_yuv420_converter_unit #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [b2y_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [b2y_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  b2y_pkg::pixel_t                pixel,
	output logic                           result_valid,
	input  logic                           result_ready,
	output b2y_pkg::result_t               result
);
	import b2y_pkg::*;

	logic      valid_s1;
	logic      valid_s2;
	logic      adv_s2;
	logic      pixel_acc;
	pixel_t    pixel_s1;
	scan_pos_t pos_cur;
	scan_pos_t pos_s1;
	result_t   result_d;
	result_t   result_s2;
	logic [7:0] luma_value;
	logic [7:0] chroma_value;

	// Handshake: each stage moves when the one after it is free or moving.
	assign cfg_ready    = 1'b1;
	assign adv_s2       = ~valid_s2 | result_ready;
	assign pixel_ready  = ~valid_s1 | adv_s2;
	assign pixel_acc    = pixel_valid & pixel_ready;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Scan counters and frame size registers.
	b2y_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (pixel_acc),
		.pos      (pos_cur)
	);

	// Colour conversion on the registered pixel.
	b2y_csc #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_csc (
		.pixel       (pixel_s1),
		.chroma_write(pos_s1.chroma_write),
		.chroma_plane(pos_s1.chroma_plane),
		.luma_value  (luma_value),
		.chroma_value(chroma_value)
	);

	// Result word assembled from the position and the converted samples.
	always_comb begin
		result_d.luma_value     = luma_value;
		result_d.luma_address   = pos_s1.luma_address;
		result_d.chroma_write   = pos_s1.chroma_write;
		result_d.chroma_plane   = pos_s1.chroma_plane;
		result_d.chroma_value   = chroma_value;
		result_d.chroma_address = pos_s1.chroma_address;
		result_d.frame_last     = pos_s1.frame_last;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel_ready) begin
				valid_s1 <= pixel_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (pixel_acc) begin
			pixel_s1 <= pixel;
			pos_s1   <= pos_cur;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	// A result without a chroma sample carries zero chroma fields.
	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.chroma_write) |->
			(result.chroma_value == 8'd0 && result.chroma_address == '0 && !result.chroma_plane))
		else $error("chroma fields not zero on an odd column");

	// The pixel after the last one of a frame starts a row at column zero.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_acc && pos_cur.frame_last) |=> pos_cur.chroma_write)
		else $error("frame did not restart at column zero");

	// The last pixel of a frame lies on row zero, so it never carries V.
	a_last_row_even: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_last) |-> !result.chroma_plane)
		else $error("last pixel of frame flagged on an odd row");

	// A stalled result word is not overwritten by the stage behind it.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready && valid_s1) |=> (valid_s1 && result_valid))
		else $error("input stage lost while output stalled");

endmodule

@@ src/b2y_scan.sv @@
// ----------------------------------------------------------------------------
// b2y_scan
// Frame size registers and the scan counters. Gives the plane addresses and
// chroma selection of the pixel presented now and steps on every accepted
// word; rows count down from the bottom of the frame.
// ----------------------------------------------------------------------------
module b2y_scan #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [b2y_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [b2y_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           advance,
	output b2y_pkg::scan_pos_t             pos
);
	import b2y_pkg::*;

	// Clamps a frame dimension to the supported range.
	function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v, input int max_v);
		logic [CNT_W-1:0] r;
		r = v;
		if (r < CNT_W'(2)) begin
			r = CNT_W'(2);
		end
		if (int'(r) > max_v) begin
			r = CNT_W'(max_v);
		end
		return r;
	endfunction

	// Reset state, worked out from the register reset values.
	localparam int RST_W_EFF = (int'(RST_FRAME_WIDTH) > MAX_WIDTH) ? MAX_WIDTH
		: int'(RST_FRAME_WIDTH);
	localparam int RST_H_EFF = (int'(RST_FRAME_HEIGHT) > MAX_HEIGHT) ? MAX_HEIGHT
		: int'(RST_FRAME_HEIGHT);
	localparam int RST_ROW = RST_H_EFF - 1;
	localparam logic [LUMA_ADDR_W-1:0] RST_LUMA_BASE = LUMA_ADDR_W'(RST_ROW * RST_W_EFF);
	localparam logic [CHROMA_ADDR_W-1:0] RST_CHROMA_BASE =
		CHROMA_ADDR_W'((RST_ROW / 2) * (RST_W_EFF / 2));

	logic [CNT_W-1:0]         frame_width_q;
	logic [CNT_W-1:0]         frame_height_q;
	logic [CNT_W-1:0]         col_q;
	logic [CNT_W-1:0]         row_q;
	logic [LUMA_ADDR_W-1:0]   luma_base_q;
	logic [CHROMA_ADDR_W-1:0] chroma_base_q;

	logic                     cfg_hit;
	logic                     cfg_we;
	logic [CNT_W-1:0]         width_nxt;
	logic [CNT_W-1:0]         height_nxt;
	logic [CNT_W-1:0]         w_eff;
	logic [CNT_W-1:0]         w_eff_nxt;
	logic [CNT_W-1:0]         h_eff_nxt;
	logic [CNT_W-1:0]         row_start;
	logic [2*CNT_W-1:0]       luma_prod;
	logic [2*CNT_W-3:0]       chroma_prod;
	logic [LUMA_ADDR_W-1:0]   luma_start;
	logic [CHROMA_ADDR_W-1:0] chroma_start;
	logic [CNT_W-2:0]         w_half;
	logic                     last_col;

	// Register decode; the frame size that applies after this cycle.
	always_comb begin
		cfg_hit    = 1'b0;
		width_nxt  = frame_width_q;
		height_nxt = frame_height_q;
		unique case (cfg_index)
			CFG_FRAME_WIDTH: begin
				cfg_hit   = 1'b1;
				width_nxt = cfg_data;
			end
			CFG_FRAME_HEIGHT: begin
				cfg_hit    = 1'b1;
				height_nxt = cfg_data;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
		if (!cfg_valid) begin
			width_nxt  = frame_width_q;
			height_nxt = frame_height_q;
		end
	end

	assign cfg_we = cfg_valid & cfg_hit;

	// Frame start position: bottom row, column zero.
	assign w_eff        = clamp_dim(frame_width_q, MAX_WIDTH);
	assign w_eff_nxt    = clamp_dim(width_nxt, MAX_WIDTH);
	assign h_eff_nxt    = clamp_dim(height_nxt, MAX_HEIGHT);
	assign row_start    = h_eff_nxt - CNT_W'(1);
	assign luma_prod    = (2*CNT_W)'(row_start) * (2*CNT_W)'(w_eff_nxt);
	assign chroma_prod  = (2*CNT_W-2)'(row_start[CNT_W-1:1]) * (2*CNT_W-2)'(w_eff_nxt[CNT_W-1:1]);
	assign luma_start   = luma_prod[LUMA_ADDR_W-1:0];
	assign chroma_start = chroma_prod[CHROMA_ADDR_W-1:0];
	assign w_half       = w_eff[CNT_W-1:1];
	assign last_col     = (col_q == w_eff - CNT_W'(1));

	// Position of the current pixel; chroma fields are zero on odd columns.
	always_comb begin
		pos.luma_address   = luma_base_q + LUMA_ADDR_W'(col_q);
		pos.chroma_write   = ~col_q[0];
		pos.chroma_plane   = 1'b0;
		pos.chroma_address = '0;
		if (!col_q[0]) begin
			pos.chroma_plane   = row_q[0];
			pos.chroma_address = chroma_base_q + CHROMA_ADDR_W'(col_q[CNT_W-1:1]);
		end
		pos.frame_last = (row_q == '0) && last_col;
	end

	// Registers and scan counters. A register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			col_q          <= '0;
			row_q          <= CNT_W'(RST_ROW);
			luma_base_q    <= RST_LUMA_BASE;
			chroma_base_q  <= RST_CHROMA_BASE;
		end else if (cfg_we) begin
			frame_width_q  <= width_nxt;
			frame_height_q <= height_nxt;
			col_q          <= '0;
			row_q          <= row_start;
			luma_base_q    <= luma_start;
			chroma_base_q  <= chroma_start;
		end else if (advance) begin
			if (!last_col) begin
				col_q <= col_q + CNT_W'(1);
			end else if (row_q == '0) begin
				col_q         <= '0;
				row_q         <= row_start;
				luma_base_q   <= luma_start;
				chroma_base_q <= chroma_start;
			end else begin
				col_q       <= '0;
				row_q       <= row_q - CNT_W'(1);
				luma_base_q <= luma_base_q - LUMA_ADDR_W'(w_eff);
				// The half row drops only when leaving an even row.
				if (!row_q[0]) begin
					chroma_base_q <= chroma_base_q - CHROMA_ADDR_W'(w_half);
				end
			end
		end
	end

endmodule

@@ src/b2y_csc.sv @@
// ----------------------------------------------------------------------------
// b2y_csc
// BT.601 studio-range colour space conversion in fixed point: Y, U and V
// with rounding offset, clamping to a byte, and chroma plane selection.
// ----------------------------------------------------------------------------
module b2y_csc #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  b2y_pkg::pixel_t pixel,
	input  logic            chroma_write,
	input  logic            chroma_plane,
	output logic [7:0]      luma_value,
	output logic [7:0]      chroma_value
);
	import b2y_pkg::*;

	localparam int ACC_W = COEF_FRAC_BITS + 11;

	// Coefficients rounded to the fixed-point grid, ties upwards.
	localparam logic signed [ACC_W-1:0] K_0257 =
		ACC_W'((longint'(257) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0504 =
		ACC_W'((longint'(504) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0098 =
		ACC_W'((longint'(98) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0148 =
		ACC_W'((longint'(148) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0291 =
		ACC_W'((longint'(291) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0439 =
		ACC_W'((longint'(439) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0368 =
		ACC_W'((longint'(368) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);
	localparam logic signed [ACC_W-1:0] K_0071 =
		ACC_W'((longint'(71) * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000);

	// Offsets 16.5 and 128.5, exact as counts of half steps.
	localparam logic signed [ACC_W-1:0] OFS_Y = ACC_W'(longint'(33) << (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] OFS_C = ACC_W'(longint'(257) << (COEF_FRAC_BITS - 1));

	// Negative sums give zero; the integer part is truncated and held at 255.
	function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
		logic [7:0] r;
		if (acc[ACC_W-1]) begin
			r = 8'd0;
		end else if (|acc[ACC_W-2:COEF_FRAC_BITS+8]) begin
			r = 8'd255;
		end else begin
			r = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
		end
		return r;
	endfunction

	logic signed [ACC_W-1:0] red_s;
	logic signed [ACC_W-1:0] green_s;
	logic signed [ACC_W-1:0] blue_s;
	logic signed [ACC_W-1:0] acc_y;
	logic signed [ACC_W-1:0] acc_u;
	logic signed [ACC_W-1:0] acc_v;

	assign red_s   = ACC_W'(pixel.red);
	assign green_s = ACC_W'(pixel.green);
	assign blue_s  = ACC_W'(pixel.blue);

	// Weighted sums of the three components.
	assign acc_y = K_0257 * red_s + K_0504 * green_s + K_0098 * blue_s + OFS_Y;
	assign acc_u = OFS_C + K_0439 * blue_s - K_0148 * red_s - K_0291 * green_s;
	assign acc_v = OFS_C + K_0439 * red_s - K_0368 * green_s - K_0071 * blue_s;

	// V goes to the second plane, U to the first; nothing on odd columns.
	always_comb begin
		luma_value = to_byte(acc_y);
		if (!chroma_write) begin
			chroma_value = 8'd0;
		end else if (chroma_plane) begin
			chroma_value = to_byte(acc_v);
		end else begin
			chroma_value = to_byte(acc_u);
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BGR to YUV 4:2:0 converter. Pixel words are
// driven with random idling on both channels, and every result word is
// checked field by field against a fixed-point conversion and scan-position
// model kept inside the bench. Frame sizes are changed only while the block
// is empty, covering the default size, the clamp limits, odd widths and
// writes to unused register indexes.
// ----------------------------------------------------------------------------
module tb;
	import b2y_pkg::*;

	localparam int FRAC_BITS      = 16;
	localparam int MAX_DIM        = 4096;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS  = 450;
	localparam int HOLD_OFF_LEN   = 60;

	// Register indexes with no register behind them.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  pixel_valid  = 1'b0;
	logic                  pixel_ready;
	pixel_t                pixel        = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	// Shared knobs between the stimulus and the receiver.
	bit idling_on     = 1'b1;
	int hold_off_left = 0;

	// Model of the converter: registers and scan position.
	logic [CNT_W-1:0] width_reg;
	logic [CNT_W-1:0] height_reg;
	int unsigned      scan_col;
	int unsigned      scan_row;
	int unsigned      luma_base;
	int unsigned      chroma_base;

	result_t predicted_yuv[$];

	int mismatch_count = 0;
	int pixels_sent    = 0;
	int words_checked  = 0;
	int frames_closed  = 0;
	int u_samples      = 0;
	int v_samples      = 0;
	int register_writes = 0;
	int idle_cycles    = 0;

	bgr_to_yuv420_converter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Conversion and scan model
	// ------------------------------------------------------------------

	function automatic int unsigned active_width();
		if (width_reg < 2) return 2;
		if (width_reg > MAX_DIM) return MAX_DIM;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned active_height();
		if (height_reg < 2) return 2;
		if (height_reg > MAX_DIM) return MAX_DIM;
		return 32'(height_reg);
	endfunction

	function automatic void move_to_row(input int unsigned row);
		int unsigned w;
		w = active_width();
		scan_row    = row;
		luma_base   = row * w;
		chroma_base = (row / 2) * (w / 2);
	endfunction

	function automatic void restart_frame();
		scan_col = 0;
		move_to_row(active_height() - 1);
	endfunction

	// Coefficient in thousandths, rounded to the fractional format.
	function automatic longint coef(input int milli);
		return (longint'(milli) * (longint'(1) <<< FRAC_BITS) + 500) / 1000;
	endfunction

	// Offset given in half units, exact in the fractional format.
	function automatic longint half_steps(input int n);
		return longint'(n) <<< (FRAC_BITS - 1);
	endfunction

	function automatic logic [7:0] saturate_byte(input longint acc);
		longint v;
		if (acc < 0) return 8'd0;
		v = acc >>> FRAC_BITS;
		if (v > 255) return 8'hFF;
		return v[7:0];
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (idx == CFG_FRAME_WIDTH) begin
			width_reg = data;
		end else if (idx == CFG_FRAME_HEIGHT) begin
			height_reg = data;
		end else begin
			return;
		end
		restart_frame();
	endfunction

	// Works out the result word for one pixel and steps the scan position.
	function automatic result_t convert_pixel(input pixel_t p);
		longint      r, g, b;
		int unsigned w;
		logic [7:0]  u_val, v_val;
		logic [31:0] addr;
		result_t     res;
		r = longint'(p.red);
		g = longint'(p.green);
		b = longint'(p.blue);
		w = active_width();
		if (scan_col >= w) scan_col = w - 1;
		res = '0;
		res.luma_value = saturate_byte(coef(257) * r + coef(504) * g + coef(98) * b
			+ half_steps(33));
		u_val = saturate_byte(-coef(148) * r - coef(291) * g + coef(439) * b
			+ half_steps(257));
		v_val = saturate_byte(coef(439) * r - coef(368) * g - coef(71) * b
			+ half_steps(257));
		addr = luma_base + scan_col;
		res.luma_address = addr[LUMA_ADDR_W-1:0];
		if (scan_col % 2 == 0) begin
			res.chroma_write   = 1'b1;
			res.chroma_plane   = scan_row[0];
			res.chroma_value   = scan_row[0] ? v_val : u_val;
			addr               = chroma_base + scan_col / 2;
			res.chroma_address = addr[CHROMA_ADDR_W-1:0];
		end
		res.frame_last = (scan_row == 0) && (scan_col == w - 1);
		if (scan_col + 1 < w) begin
			scan_col++;
		end else if (scan_row == 0) begin
			restart_frame();
		end else begin
			scan_col = 0;
			move_to_row(scan_row - 1);
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	function automatic pixel_t make_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		pixel_t p;
		p.blue  = b;
		p.green = g;
		p.red   = r;
		return p;
	endfunction

	// Mostly uniform, with the rails picked now and then.
	function automatic logic [7:0] random_channel();
		case ($urandom_range(9))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(255));
			end
		endcase
	endfunction

	// Offers one pixel word, with a random gap first, and records its result.
	task automatic send_pixel(input pixel_t p);
		cfg_valid <= 1'b0;
		while (idling_on && $urandom_range(99) < 35) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		predicted_yuv.push_back(convert_pixel(p));
		pixels_sent++;
	endtask

	task automatic wait_drained();
		pixel_valid <= 1'b0;
		cfg_valid   <= 1'b0;
		while (predicted_yuv.size() != 0) @(posedge clk);
	endtask

	// Register writes go in only once every pending word has come out.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		pixel_valid <= 1'b0;
		while (predicted_yuv.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_register(idx, data);
		register_writes++;
	endtask

	task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		write_register(CFG_FRAME_WIDTH, w);
		write_register(CFG_FRAME_HEIGHT, h);
	endtask

	// ------------------------------------------------------------------
	// Receiver and checking
	// ------------------------------------------------------------------

	// Random stalls, or a forced hold-off when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_off_left > 0) begin
			hold_off_left = hold_off_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= !(idling_on && $urandom_range(99) < 35);
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input int word, input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got 0x%0h, expected 0x%0h",
				word, field, got, want));
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (predicted_yuv.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing pending",
					words_checked));
			end else begin
				want = predicted_yuv.pop_front();
				check_field(words_checked, "luma_value", result.luma_value, want.luma_value);
				check_field(words_checked, "luma_address", result.luma_address,
					want.luma_address);
				check_field(words_checked, "chroma_write", result.chroma_write,
					want.chroma_write);
				check_field(words_checked, "chroma_plane", result.chroma_plane,
					want.chroma_plane);
				check_field(words_checked, "chroma_value", result.chroma_value,
					want.chroma_value);
				check_field(words_checked, "chroma_address", result.chroma_address,
					want.chroma_address);
				check_field(words_checked, "frame_last", result.frame_last, want.frame_last);
				if (want.frame_last) frames_closed++;
				if (want.chroma_write && want.chroma_plane) v_samples++;
				if (want.chroma_write && !want.chroma_plane) u_samples++;
			end
			words_checked++;
		end
	end

	// Ends the run if no channel moves a word for too long.
	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset size: the scan starts on row 239, an odd row, so V comes first.
	task automatic test_default_frame();
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
		send_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
	endtask

	// Smallest frame: both chroma planes and the frame marker, then wrap.
	task automatic test_small_frames();
		set_frame(13'd2, 13'd2);
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h00));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'h00));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF));
		send_pixel(make_pixel(8'h80, 8'h80, 8'h80));
		send_pixel(make_pixel(8'h01, 8'hFE, 8'h7F));
	endtask

	// Sizes below two, above the maximum, and an odd width and height.
	task automatic test_size_clamping();
		set_frame(13'd0, 13'd1);
		repeat (4) send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
		set_frame(13'h1FFF, 13'h1FFF);
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
		send_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
		set_frame(13'd3, 13'd3);
		repeat (4) send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
	endtask

	// Writes to unused indexes must leave the scan where it was.
	task automatic test_unused_index();
		set_frame(13'd2, 13'd2);
		repeat (2) send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
		write_register(CFG_UNUSED_A, 13'h1FFF);
		write_register(CFG_UNUSED_B, 13'h0000);
		repeat (2) send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
	endtask

	// Receiver holds off while pixels keep coming, then the sender waits for
	// every word to come out before going on.
	task automatic test_backpressure();
		set_frame(13'd8, 13'd4);
		idling_on = 1'b0;
		hold_off_left = HOLD_OFF_LEN;
		repeat (20) send_pixel(make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255))));
		wait_drained();
		idling_on = 1'b1;
	endtask

	// Random frame sizes, mostly small so that frames complete often.
	task automatic test_random_frames();
		int sent;
		int phase;
		int phase_len;
		logic [CFG_DATA_W-1:0] w, h;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			// The second phase runs with no idling on either side.
			idling_on = (phase != 1);
			case ($urandom_range(9))
				0: begin
					w = CFG_DATA_W'($urandom_range(8191));
					h = CFG_DATA_W'($urandom_range(8191));
				end
				1: begin
					w = CFG_DATA_W'($urandom_range(2, 9));
					h = CFG_DATA_W'($urandom_range(2, 7));
				end
				default: begin
					w = CFG_DATA_W'(2 * $urandom_range(1, 8));
					h = CFG_DATA_W'(2 * $urandom_range(1, 4));
				end
			endcase
			case ($urandom_range(5))
				0: begin
					write_register(CFG_FRAME_WIDTH, w);
				end
				1: begin
					write_register(CFG_FRAME_HEIGHT, h);
					write_register(CFG_FRAME_WIDTH, w);
				end
				2: begin
					set_frame(w, h);
					write_register($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B,
						CFG_DATA_W'($urandom_range(8191)));
				end
				default: begin
					set_frame(w, h);
				end
			endcase
			phase_len = (phase == 1) ? 150 : $urandom_range(15, 60);
			repeat (phase_len)
				send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
			sent += phase_len;
			phase++;
		end
		idling_on = 1'b1;
	endtask

	initial begin
		width_reg  = RST_FRAME_WIDTH;
		height_reg = RST_FRAME_HEIGHT;
		restart_frame();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_frame();
		test_small_frames();
		test_size_clamping();
		test_unused_index();
		test_backpressure();
		test_random_frames();

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Run covered %0d pixels, %0d result words, %0d complete frames,",
			pixels_sent, words_checked, frames_closed);
		$display("%0d U and %0d V samples, %0d register writes, %0d mismatches.",
			u_samples, v_samples, register_writes, mismatch_count);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/b2y_pkg.sv
src/b2y_scan.sv
src/b2y_csc.sv
src/bgr_to_yuv420_converter_unit.sv
verif/tb.sv
